FILE: hw/rtl/msfd_pkg.sv
// ----------------------------------------------------------------------------
// msfd_pkg
// Shared widths, event codes and control structs of the FIFO dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package msfd_pkg;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned SRV_IDX_W = 3;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned QLEN_W    = 5;
  localparam int unsigned TIME_W    = 4;

  typedef enum logic [KIND_W-1:0] {
    EV_ARRIVED  = 3'd0,
    EV_FINISHED = 3'd1,
    EV_STARTED  = 3'd2,
    EV_SUMMARY  = 3'd3,
    EV_DROPPED  = 3'd4
  } event_kind_e;

  // Commands from the sequencer to the datapath. Every emitting command is
  // only raised when the output register can take a new transaction.
  typedef struct packed {
    logic load;     // capture the input transaction
    logic arrive;   // handle the arrival of the tick
    logic check;    // count down the current server
    logic start;    // hand the FIFO head to the current server
    logic summary;  // emit the tick summary
    logic srv_clr;  // restart the server scan at index zero
    logic srv_inc;  // move on to the next server
  } msfd_cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being drained
    logic last_srv;  // scan is at the highest server index
  } msfd_status_t;

endpackage : msfd_pkg

`default_nettype wire

FILE: hw/rtl/msfd_ctrl.sv
// ----------------------------------------------------------------------------
// msfd_ctrl
// Tick sequencer: arrival, then check and start for each server, then summary.
// ----------------------------------------------------------------------------
`default_nettype none

module msfd_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire msfd_pkg::msfd_status_t status_i,
  output msfd_pkg::msfd_cmd_t        cmd_o
);
  import msfd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ARR   = 5'b00010,
    ST_CHK   = 5'b00100,
    ST_START = 5'b01000,
    ST_SUM   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ARR;
        end
      end
      ST_ARR: begin
        if (status_i.out_free) begin
          cmd_o.arrive  = 1'b1;
          cmd_o.srv_clr = 1'b1;
          state_d       = ST_CHK;
        end
      end
      ST_CHK: begin
        if (status_i.out_free) begin
          cmd_o.check = 1'b1;
          state_d     = ST_START;
        end
      end
      ST_START: begin
        if (status_i.out_free) begin
          cmd_o.start = 1'b1;
          if (status_i.last_srv) begin
            state_d = ST_SUM;
          end else begin
            cmd_o.srv_inc = 1'b1;
            state_d       = ST_CHK;
          end
        end
      end
      ST_SUM: begin
        if (status_i.out_free) begin
          cmd_o.summary = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : msfd_ctrl

`default_nettype wire

FILE: hw/rtl/msfd_dp.sv
// ----------------------------------------------------------------------------
// msfd_dp
// Datapath: waiting-job FIFO memory, server registers, counters and the
// registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module msfd_dp #(
  parameter int unsigned NUM_SERVERS = 3,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire msfd_pkg::msfd_cmd_t               cmd_i,
  output msfd_pkg::msfd_status_t                 status_o,
  input  wire logic                              arrival_i,
  input  wire logic [msfd_pkg::TIME_W-1:0]       service_time_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [msfd_pkg::KIND_W-1:0]            event_kind_o,
  output logic [msfd_pkg::SRV_IDX_W-1:0]         server_index_o,
  output logic [msfd_pkg::ID_W-1:0]              job_id_o,
  output logic [msfd_pkg::QLEN_W-1:0]            queue_length_o,
  output logic [msfd_pkg::ID_W-1:0]              served_total_o,
  output logic                                   last_o
);
  import msfd_pkg::*;

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SRV_AW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  // Captured input transaction.
  logic              arr_q;
  logic [TIME_W-1:0] time_q;

  // FIFO storage, no reset: only written entries are ever read.
  logic [ID_W-1:0]   mem_id   [QUEUE_DEPTH];
  logic [TIME_W-1:0] mem_time [QUEUE_DEPTH];
  logic [ID_W-1:0]   rd_id_q;
  logic [TIME_W-1:0] rd_time_q;

  logic [PTR_W-1:0]  head_q, tail_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ID_W-1:0]   next_id_q, served_q, served_d;
  logic [SRV_AW-1:0] srv_q;
  logic [TIME_W-1:0] rem_q [NUM_SERVERS];
  logic [ID_W-1:0]   job_q [NUM_SERVERS];

  logic              full;
  logic              wr_en;
  logic [ID_W-1:0]   id_inc;
  logic [TIME_W-1:0] time_eff;
  logic              do_finish, do_start, emit;
  logic [KIND_W-1:0] kind_d;
  logic [ID_W-1:0]   job_d;
  logic              last_d;
  logic [SRV_IDX_W+SRV_AW-1:0] srv_ext;
  logic [QLEN_W+CNT_W-1:0]     qlen_ext;

  // Output register.
  logic                 out_valid_q;
  logic [KIND_W-1:0]    kind_q;
  logic [SRV_IDX_W-1:0] srv_out_q;
  logic [ID_W-1:0]      job_out_q;
  logic [QLEN_W-1:0]    qlen_q;
  logic [ID_W-1:0]      served_out_q;
  logic                 last_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.last_srv = (srv_q == SRV_AW'(NUM_SERVERS - 1));

  assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign id_inc   = next_id_q + 1'b1;
  assign time_eff = (time_q == '0) ? TIME_W'(1) : time_q;
  assign wr_en    = cmd_i.arrive && arr_q && !full;

  // A finish is a countdown from one; the start sees the updated count.
  assign do_finish = cmd_i.check && (rem_q[srv_q] == TIME_W'(1));
  assign do_start  = cmd_i.start && (rem_q[srv_q] == '0) && (cnt_q != '0);

  assign emit = (cmd_i.arrive && arr_q) || do_finish || do_start || cmd_i.summary;

  always_comb begin
    cnt_d    = cnt_q;
    served_d = served_q;
    kind_d   = EV_SUMMARY;
    job_d    = '0;
    last_d   = 1'b0;
    if (cmd_i.arrive) begin
      kind_d = full ? EV_DROPPED : EV_ARRIVED;
      job_d  = id_inc;
      if (!full && arr_q) begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (do_finish) begin
      kind_d   = EV_FINISHED;
      job_d    = job_q[srv_q];
      served_d = served_q + 1'b1;
    end else if (do_start) begin
      kind_d = EV_STARTED;
      job_d  = rd_id_q;
      cnt_d  = cnt_q - 1'b1;
    end else if (cmd_i.summary) begin
      last_d = 1'b1;
    end
  end

  // Only finished and started events carry a server index.
  assign srv_ext  = (do_finish || do_start) ? {{SRV_IDX_W{1'b0}}, srv_q} : '0;
  assign qlen_ext = {{QLEN_W{1'b0}}, cnt_d};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_id[tail_q]   <= id_inc;
      mem_time[tail_q] <= time_eff;
    end
    rd_id_q   <= mem_id[head_q];
    rd_time_q <= mem_time[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      arr_q  <= arrival_i;
      time_q <= service_time_i;
    end
    if (emit) begin
      kind_q       <= kind_d;
      srv_out_q    <= srv_ext[SRV_IDX_W-1:0];
      job_out_q    <= job_d;
      qlen_q       <= qlen_ext[QLEN_W-1:0];
      served_out_q <= served_d;
      last_q       <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      next_id_q   <= '0;
      served_q    <= '0;
      srv_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        rem_q[i] <= '0;
        job_q[i] <= '0;
      end
    end else begin
      cnt_q    <= cnt_d;
      served_q <= served_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.arrive && arr_q) begin
        next_id_q <= id_inc;
      end
      if (wr_en) begin
        tail_q <= (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
      end
      if (cmd_i.srv_clr) begin
        srv_q <= '0;
      end else if (cmd_i.srv_inc) begin
        srv_q <= srv_q + 1'b1;
      end
      if (cmd_i.check && (rem_q[srv_q] != '0)) begin
        rem_q[srv_q] <= rem_q[srv_q] - 1'b1;
      end
      if (do_finish) begin
        job_q[srv_q] <= '0;
      end
      if (do_start) begin
        rem_q[srv_q] <= rd_time_q;
        job_q[srv_q] <= rd_id_q;
        head_q <= (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign server_index_o = srv_out_q;
  assign job_id_o       = job_out_q;
  assign queue_length_o = qlen_q;
  assign served_total_o = served_out_q;
  assign last_o         = last_q;

endmodule : msfd_dp

`default_nettype wire

FILE: hw/rtl/multi_server_fifo_dispatcher.sv
// ----------------------------------------------------------------------------
// multi_server_fifo_dispatcher
// Tick-driven queue with a FIFO of waiting jobs and several servers.
// ----------------------------------------------------------------------------
// A tick runs from acceptance through the arrival step to the summary event,
// with the sequencer visiting each server in two steps, check and start.
// The next tick is accepted in the cycle after the summary enters the output
// register; a new tick is not taken before the last one is through.
// An arrival event is registered in the arrival step that follows acceptance.
// Output stalls hold the sequencer. Reset clears pointers, counters and servers
// at once; the FIFO storage has no reset and needs no clearing pass.
`default_nettype none

module multi_server_fifo_dispatcher #(
  parameter int unsigned NUM_SERVERS = 3,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          arrival_i,
  input  wire logic [msfd_pkg::TIME_W-1:0]   service_time_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [msfd_pkg::KIND_W-1:0]        event_kind_o,
  output logic [msfd_pkg::SRV_IDX_W-1:0]     server_index_o,
  output logic [msfd_pkg::ID_W-1:0]          job_id_o,
  output logic [msfd_pkg::QLEN_W-1:0]        queue_length_o,
  output logic [msfd_pkg::ID_W-1:0]          served_total_o,
  output logic                               last_o
);
  import msfd_pkg::*;

  msfd_cmd_t    cmd;
  msfd_status_t status;

  msfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  msfd_dp #(
    .NUM_SERVERS (NUM_SERVERS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .arrival_i      (arrival_i),
    .service_time_i (service_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .server_index_o (server_index_o),
    .job_id_o       (job_id_o),
    .queue_length_o (queue_length_o),
    .served_total_o (served_total_o),
    .last_o         (last_o)
  );

endmodule : multi_server_fifo_dispatcher

`default_nettype wire

FILE: test/msfd_checker.sv
// ----------------------------------------------------------------------------
// msfd_checker
// Watches both channels of the FIFO dispatcher, keeps its own model of queue
// and servers, and compares each event against the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module msfd_checker #(
  parameter int unsigned NUM_SERVERS = 3,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_ready_i,
  input  wire logic                           arrival_i,
  input  wire logic [msfd_pkg::TIME_W-1:0]    service_time_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_ready_i,
  input  wire logic [msfd_pkg::KIND_W-1:0]    event_kind_i,
  input  wire logic [msfd_pkg::SRV_IDX_W-1:0] server_index_i,
  input  wire logic [msfd_pkg::ID_W-1:0]      job_id_i,
  input  wire logic [msfd_pkg::QLEN_W-1:0]    queue_length_i,
  input  wire logic [msfd_pkg::ID_W-1:0]      served_total_i,
  input  wire logic                           last_i,
  output int                                  mismatch_count_o,
  output int                                  pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import msfd_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    event_kind_e            kind;
    logic [SRV_IDX_W-1:0]   srv;
    logic [ID_W-1:0]        job;
    logic [QLEN_W-1:0]      qlen;
    logic [ID_W-1:0]        served;
    logic                   last;
  } dispatch_event_t;

  logic [ID_W-1:0]   wait_job   [QUEUE_DEPTH];
  logic [TIME_W-1:0] wait_len   [QUEUE_DEPTH];
  int unsigned       queue_head;
  int unsigned       queue_tail;
  int unsigned       queue_fill;
  logic [TIME_W-1:0] srv_left   [NUM_SERVERS];
  logic [ID_W-1:0]   srv_job    [NUM_SERVERS];
  logic [ID_W-1:0]   id_counter;
  logic [ID_W-1:0]   finished_jobs;

  dispatch_event_t   expected_events[$];

  task automatic log_event(input event_kind_e kind, input logic [SRV_IDX_W-1:0] srv,
                           input logic [ID_W-1:0] job, input logic last);
    dispatch_event_t ev;
    ev.kind   = kind;
    ev.srv    = srv;
    ev.job    = job;
    ev.qlen   = QLEN_W'(queue_fill);
    ev.served = finished_jobs;
    ev.last   = last;
    expected_events.push_back(ev);
  endtask

  // One tick: the arrival first, then every server in index order, then the
  // summary that closes the tick.
  task automatic run_tick(input logic arr, input logic [TIME_W-1:0] st);
    logic [TIME_W-1:0] dur;
    if (arr) begin
      dur = (st == '0) ? TIME_W'(1) : st;
      id_counter = id_counter + 1'b1;
      if (queue_fill >= QUEUE_DEPTH) begin
        log_event(EV_DROPPED, '0, id_counter, 1'b0);
      end else begin
        wait_job[queue_tail] = id_counter;
        wait_len[queue_tail] = dur;
        queue_tail = (queue_tail + 1 >= QUEUE_DEPTH) ? 0 : queue_tail + 1;
        queue_fill++;
        log_event(EV_ARRIVED, '0, id_counter, 1'b0);
      end
    end
    for (int s = 0; s < NUM_SERVERS; s++) begin
      if (srv_left[s] != '0) begin
        srv_left[s] = srv_left[s] - 1'b1;
        if (srv_left[s] == '0) begin
          finished_jobs = finished_jobs + 1'b1;
          log_event(EV_FINISHED, SRV_IDX_W'(s), srv_job[s], 1'b0);
          srv_job[s] = '0;
        end
      end
      // A server that just finished may pick up the next job in the same tick.
      if (srv_left[s] == '0 && queue_fill > 0) begin
        srv_job[s]  = wait_job[queue_head];
        srv_left[s] = wait_len[queue_head];
        queue_head  = (queue_head + 1 >= QUEUE_DEPTH) ? 0 : queue_head + 1;
        queue_fill--;
        log_event(EV_STARTED, SRV_IDX_W'(s), srv_job[s], 1'b0);
      end
    end
    log_event(EV_SUMMARY, '0, '0, 1'b1);
  endtask

  task automatic check_event();
    dispatch_event_t want;
    if (expected_events.size() == 0) begin
      mismatch_count_o++;
      if (mismatch_count_o <= MAX_REPORTS)
        $display("%0t: event without a pending expectation: kind %0d srv %0d job %0d",
                 $realtime, event_kind_i, server_index_i, job_id_i);
    end else begin
      want = expected_events.pop_front();
      if (event_kind_i !== want.kind || server_index_i !== want.srv ||
          job_id_i !== want.job || queue_length_i !== want.qlen ||
          served_total_i !== want.served || last_i !== want.last) begin
        mismatch_count_o++;
        if (mismatch_count_o <= MAX_REPORTS) begin
          $display("%0t: expected kind %0d srv %0d job %0d qlen %0d served %0d last %0b",
                   $realtime, want.kind, want.srv, want.job, want.qlen, want.served,
                   want.last);
          $display("%0t: actual   kind %0d srv %0d job %0d qlen %0d served %0d last %0b",
                   $realtime, event_kind_i, server_index_i, job_id_i, queue_length_i,
                   served_total_i, last_i);
        end
      end
    end
  endtask

  // Output events are compared before the input is modeled; a tick accepted
  // at this edge cannot have produced an event yet.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < QUEUE_DEPTH; q++) begin
        wait_job[q] = '0;
        wait_len[q] = '0;
      end
      for (int s = 0; s < NUM_SERVERS; s++) begin
        srv_left[s] = '0;
        srv_job[s]  = '0;
      end
      queue_head       = 0;
      queue_tail       = 0;
      queue_fill       = 0;
      id_counter       = '0;
      finished_jobs    = '0;
      mismatch_count_o = 0;
      expected_events.delete();
      pending_o        = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_event();
      if (in_valid_i && in_ready_i) run_tick(arrival_i, service_time_i);
      pending_o = expected_events.size();
    end
  end

endmodule : msfd_checker

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives ticks into the FIFO dispatcher with random gaps and output stalls:
// a directed overflow sequence followed by random traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import msfd_pkg::*;

  localparam int unsigned NUM_SERVERS = 3;
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int          STALL_LIMIT = 1000;
  localparam int          MAX_GAP     = 17;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 arrival = 1'b0;
  logic [TIME_W-1:0]    service_time = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    event_kind;
  logic [SRV_IDX_W-1:0] server_index;
  logic [ID_W-1:0]      job_id;
  logic [QLEN_W-1:0]    queue_length;
  logic [ID_W-1:0]      served_total;
  logic                 ev_last;
  int                   mismatches;
  int                   pending;
  int                   stuck_cycles = 0;
  logic                 gaps_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_server_fifo_dispatcher #(
    .NUM_SERVERS(NUM_SERVERS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .arrival_i     (arrival),
    .service_time_i(service_time),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .event_kind_o  (event_kind),
    .server_index_o(server_index),
    .job_id_o      (job_id),
    .queue_length_o(queue_length),
    .served_total_o(served_total),
    .last_o        (ev_last)
  );

  msfd_checker #(
    .NUM_SERVERS(NUM_SERVERS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .arrival_i       (arrival),
    .service_time_i  (service_time),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .event_kind_i    (event_kind),
    .server_index_i  (server_index),
    .job_id_i        (job_id),
    .queue_length_i  (queue_length),
    .served_total_i  (served_total),
    .last_i          (ev_last),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // With gaps on, waits are drawn from the full range; with gaps off most of them
  // are forced to zero so that long back-to-back runs occur.
  function automatic int draw_wait();
    if (gaps_on || ($urandom_range(0, 3) == 0)) begin
      return int'($urandom_range(0, MAX_GAP));
    end
    return 0;
  endfunction

  // Called and returning at a falling edge. Valid stays high between
  // back-to-back ticks.
  task automatic send_tick(input logic arr, input logic [TIME_W-1:0] st);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    arrival      <= arr;
    service_time <= st;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Receiver: a random stall before each transaction.
  initial begin
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int arr_pct;
    logic long_jobs;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // An empty tick, service times 0, 1, 4 and 8, then enough
    // long jobs back to back to overflow the queue and force drops.
    send_tick(1'b0, 4'd15);
    send_tick(1'b1, 4'd0);
    send_tick(1'b1, 4'd1);
    send_tick(1'b1, 4'd4);
    send_tick(1'b1, 4'd8);
    repeat (22) send_tick(1'b1, 4'd15);
    drain_events();

    for (int g = 0; g < 13; g++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0: arr_pct = 20;
        1: arr_pct = 50;
        default: arr_pct = 90;
      endcase
      long_jobs = 1'($urandom_range(0, 1));
      for (int k = 0; k < 30; k++) begin
        send_tick($urandom_range(1, 100) <= arr_pct,
                  long_jobs ? TIME_W'($urandom_range(8, 15)) : TIME_W'($urandom_range(0, 15)));
      end
      if (g == 6) drain_events();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule : tb_top

`default_nettype wire
